[design/tcaof_pkg.sv]
// ----------------------------------------------------------------------------
// tcaof_pkg
// Shared constants, codes and types of the two-class age-ordered fifo.
// ----------------------------------------------------------------------------
package tcaof_pkg;

    // default number of entries per class
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W     = 32;
    localparam int SERIAL_W = 32;

    // mode codes
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TAKE   = 1'b1;

    // take preference codes
    localparam logic [1:0] PREF_OLDEST = 2'd0;
    localparam logic [1:0] PREF_POS    = 2'd1;
    localparam logic [1:0] PREF_NEG    = 2'd2;

    // one stored entry: arrival serial and identifier
    typedef struct packed {
        logic [SERIAL_W-1:0]    serial;
        logic signed [ID_W-1:0] id;
    } tcaof_entry_t;

    // commands from the sequencer to one class queue
    typedef struct packed {
        logic push;
        logic pop;
    } tcaof_qcmd_t;

    // status from one class queue to the sequencer
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } tcaof_qstat_t;

endpackage

[design/tcaof_if.sv]
// ----------------------------------------------------------------------------
// tcaof interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tcaof_in_if;
    logic              valid;
    logic              ready;
    logic              mode;
    logic signed [31:0] entry_id;
    logic [1:0]        preference;

    modport source (output valid, output mode, output entry_id, output preference,
                    input ready);
    modport sink   (input valid, input mode, input entry_id, input preference,
                    output ready);
endinterface

interface tcaof_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] taken_id;

    modport source (output valid, output taken_id, input ready);
    modport sink   (input valid, input taken_id, output ready);
endinterface

[design/tcaof_ram.sv]
// ----------------------------------------------------------------------------
// tcaof_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcaof_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/tcaof_queue.sv]
// ----------------------------------------------------------------------------
// tcaof_queue
// One class queue: entry RAM plus head pointer and fill count.
// ----------------------------------------------------------------------------
module tcaof_queue
    import tcaof_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  tcaof_qcmd_t  cmd,
    input  tcaof_entry_t push_entry,
    output tcaof_qstat_t stat,
    output tcaof_entry_t head_entry
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S = (AW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_S  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_S  = CW'(QUEUE_DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail_addr;

    // tail position, head plus count folded once
    always_comb
    begin
        tail_sum = {1'b0, head_reg} + (AW+1)'(count_reg);
        if (tail_sum >= DEPTH_S)
        begin
            tail_sum = tail_sum - DEPTH_S;
        end
        tail_addr = tail_sum[AW-1:0];
    end

    // pointer and count update
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop)
        begin
            head_next  = (head_reg == LAST_S) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (cmd.push)
        begin
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign stat.not_empty = (count_reg != '0);
    assign stat.not_full  = (count_reg != FULL_S);

    // entry storage, read address follows the head
    tcaof_ram #(
        .WIDTH ($bits(tcaof_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (tail_addr),
        .wdata (push_entry),
        .raddr (head_reg),
        .rdata (head_entry)
    );

endmodule

[design/two_class_age_ordered_fifo.sv]
// ----------------------------------------------------------------------------
// two_class_age_ordered_fifo
// Two per-class fifos of serial-tagged identifiers; takes pick a class or the
// oldest head by a wrap-aware serial compare.
// ----------------------------------------------------------------------------
//   channel   dir  fields                          item
//   in_ch     in   mode, entry_id, preference      arrival or take request
//   out_ch    out  taken_id                        identifier removed by a take
//
// an arrival is written into its class RAM as it is accepted, unless its id is
// zero or its class is full; a take is accepted, then decided in the take state
// from the registered RAM head read, which it pops if there is one
// a take waits in the take state while the result register is full and
// stalled; the result register otherwise frees the input side
// reset clears pointers, counts and the serial (to one); the RAMs are not cleared
// ----------------------------------------------------------------------------
module two_class_age_ordered_fifo
    import tcaof_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tcaof_in_if.sink    in_ch,
    tcaof_out_if.source out_ch
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TAKE = 1'b1;

    logic                   state_reg, state_next;
    logic [1:0]             pref_reg;
    logic [SERIAL_W-1:0]    serial_reg, serial_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [ID_W-1:0] out_id_reg, out_id_next;

    tcaof_qcmd_t  pos_cmd, neg_cmd;
    tcaof_qstat_t pos_stat, neg_stat;
    tcaof_entry_t push_entry, pos_head, neg_head;

    logic                in_acc;
    logic                out_free;
    logic                have_result;
    logic                take_negative;
    logic [SERIAL_W-1:0] serial_diff;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_acc       = in_ch.valid && in_ch.ready;
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.taken_id = out_id_reg;

    assign push_entry.serial = serial_reg;
    assign push_entry.id     = in_ch.entry_id;

    // wrap-aware age compare of the two heads
    assign serial_diff = neg_head.serial - pos_head.serial;

    // class choice for a pending take
    always_comb
    begin
        have_result   = 1'b0;
        take_negative = 1'b0;
        case (pref_reg)
            PREF_POS:
            begin
                have_result = pos_stat.not_empty;
            end
            PREF_NEG:
            begin
                have_result   = neg_stat.not_empty;
                take_negative = 1'b1;
            end
            PREF_OLDEST:
            begin
                have_result = pos_stat.not_empty || neg_stat.not_empty;
                if (pos_stat.not_empty && neg_stat.not_empty)
                begin
                    take_negative = serial_diff[SERIAL_W-1];
                end
                else
                begin
                    take_negative = neg_stat.not_empty;
                end
            end
            default:
            begin
                have_result = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        serial_next    = serial_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_id_next    = out_id_reg;
        pos_cmd        = '0;
        neg_cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.mode == MODE_TAKE)
                    begin
                        state_next = ST_TAKE;
                    end
                    else if (in_ch.entry_id != '0)
                    begin
                        if (in_ch.entry_id[ID_W-1])
                        begin
                            neg_cmd.push = neg_stat.not_full;
                        end
                        else
                        begin
                            pos_cmd.push = pos_stat.not_full;
                        end
                        if (neg_cmd.push || pos_cmd.push)
                        begin
                            serial_next = serial_reg + 1'b1;
                        end
                    end
                end
            end
            ST_TAKE:
            begin
                if (!have_result)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_id_next    = take_negative ? neg_head.id : pos_head.id;
                    neg_cmd.pop    = take_negative;
                    pos_cmd.pop    = !take_negative;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            serial_reg    <= SERIAL_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            serial_reg    <= serial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_id_reg <= out_id_next;
        if (in_acc)
        begin
            pref_reg <= in_ch.preference;
        end
    end

    // class queues
    tcaof_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_pos_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (pos_cmd),
        .push_entry (push_entry),
        .stat       (pos_stat),
        .head_entry (pos_head)
    );

    tcaof_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_neg_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (neg_cmd),
        .push_entry (push_entry),
        .stat       (neg_stat),
        .head_entry (neg_head)
    );

    // checks
    a_pos_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pos_cmd.pop |-> pos_stat.not_empty)
        else $error("pop from empty positive queue");

    a_neg_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        neg_cmd.push |-> neg_stat.not_full)
        else $error("push into full negative queue");

    a_result_from_take: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_TAKE))
        else $error("result raised outside a take");

    a_one_queue_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !((pos_cmd.push || pos_cmd.pop) && (neg_cmd.push || neg_cmd.pop)))
        else $error("both queues changed by one item");

endmodule

[tb/tb_two_class_age_ordered_fifo.sv]
// ----------------------------------------------------------------------------
// tb_two_class_age_ordered_fifo
// Self-checking bench for the two-class age-ordered fifo. A directed table
// covers empty takes, dropped arrivals, extreme identifiers and the three
// preferences. Random traffic follows: class fill bursts past the queue
// depth, mixed arrivals and takes, and drain pauses. Every taken_id is checked
// in order against the table's expected id or a behavioral shelter model. Both
// channels idle at random, and one long result stall backs up the input side.
// ----------------------------------------------------------------------------
module tb_two_class_age_ordered_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import tcaof_pkg::*;

    localparam int TOTAL_ITEMS  = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_N        = 26;

    // preference code with no meaning, a take carrying it is ignored
    localparam logic [1:0] PREF_NONE = 2'd3;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ID
    } chk_kind_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] entry_id;
        logic [1:0]         pref;
        chk_kind_t          chk;
        logic signed [31:0] want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    tcaof_in_if  in_if ();
    tcaof_out_if out_if ();

    two_class_age_ordered_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    // shelter model state
    tcaof_entry_t       pos_q[$];
    tcaof_entry_t       neg_q[$];
    logic [31:0]        serial_ctr;

    // taken identifiers still due, oldest first
    logic signed [31:0] taken_q[$];
    logic signed [31:0] want_id;

    bit hold_rx   = 1'b0;
    bit tx_quiet  = 1'b0;
    bit rx_quiet  = 1'b0;
    int errors        = 0;
    int items_sent    = 0;
    int ids_checked   = 0;
    int full_drops    = 0;
    int zero_drops    = 0;
    int ignored_takes = 0;
    int idle_cycles   = 0;

    // directed table
    dir_row_t dir_tab [DIR_N] = '{
        // takes on an empty block
        '{MODE_TAKE,   32'sd0,            PREF_OLDEST, CHK_NONE,  32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_POS,    CHK_NONE,  32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_NEG,    CHK_NONE,  32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_NONE,   CHK_NONE,  32'sd0},
        // zero identifier is dropped
        '{MODE_ARRIVE, 32'sd0,            PREF_OLDEST, CHK_NONE,  32'sd0},
        // extremes of both classes
        '{MODE_ARRIVE, 32'sh7fff_ffff,    PREF_NONE,   CHK_NONE,  32'sd0},
        '{MODE_ARRIVE, 32'sh8000_0000,    PREF_OLDEST, CHK_NONE,  32'sd0},
        '{MODE_ARRIVE, 32'sd1,            PREF_POS,    CHK_NONE,  32'sd0},
        '{MODE_ARRIVE, -32'sd1,           PREF_NEG,    CHK_NONE,  32'sd0},
        // meaningless preference with entries waiting
        '{MODE_TAKE,   32'sd0,            PREF_NONE,   CHK_NONE,  32'sd0},
        // oldest first, entry_id ignored on a take
        '{MODE_TAKE,   32'sh5a5a_5a5a,    PREF_OLDEST, CHK_ID,    32'sh7fff_ffff},
        '{MODE_TAKE,   -32'sd1,           PREF_OLDEST, CHK_ID,    32'sh8000_0000},
        '{MODE_TAKE,   32'sd0,            PREF_NEG,    CHK_ID,    -32'sd1},
        '{MODE_TAKE,   32'sd0,            PREF_POS,    CHK_ID,    32'sd1},
        '{MODE_TAKE,   32'sd0,            PREF_OLDEST, CHK_NONE,  32'sd0},
        // class preference skips an older head of the other class
        '{MODE_ARRIVE, -32'sd5,           PREF_OLDEST, CHK_NONE,  32'sd0},
        '{MODE_ARRIVE, 32'sd6,            PREF_OLDEST, CHK_NONE,  32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_POS,    CHK_ID,    32'sd6},
        '{MODE_TAKE,   32'sd0,            PREF_OLDEST, CHK_ID,    -32'sd5},
        // one class empty, the other not
        '{MODE_ARRIVE, 32'sd2,            PREF_NEG,    CHK_NONE,  32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_NEG,    CHK_NONE,  32'sd0},
        '{MODE_ARRIVE, 32'shc000_0000,    PREF_POS,    CHK_NONE,  32'sd0},
        '{MODE_ARRIVE, 32'sh4000_0000,    PREF_NONE,   CHK_NONE,  32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_OLDEST, CHK_MODEL, 32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_OLDEST, CHK_MODEL, 32'sd0},
        '{MODE_TAKE,   32'sd0,            PREF_OLDEST, CHK_MODEL, 32'sd0}
    };

    // clock and reset
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // shelter model: one request in, returns 1 when an identifier is taken
    function automatic bit shelter_step(input logic mode, input logic signed [31:0] id,
                                        input logic [1:0] pref,
                                        output logic signed [31:0] out_id);
        tcaof_entry_t e;
        logic [31:0]  age_gap;
        bit           from_neg;
        out_id = '0;
        from_neg = 1'b0;
        e.serial = serial_ctr;
        e.id = id;
        // arrivals: sign picks the class, zero and full class drop
        if (mode == MODE_ARRIVE)
        begin
            if (id == 0)
            begin
                zero_drops++;
                return 1'b0;
            end
            if (id[31])
            begin
                if (neg_q.size() < QUEUE_DEPTH_DEF)
                begin
                    neg_q = {neg_q, e};
                    serial_ctr++;
                end
                else
                    full_drops++;
            end
            else
            begin
                if (pos_q.size() < QUEUE_DEPTH_DEF)
                begin
                    pos_q = {pos_q, e};
                    serial_ctr++;
                end
                else
                    full_drops++;
            end
            return 1'b0;
        end
        // takes: choose a class, or the older head by serial difference
        case (pref)
            PREF_POS:
            begin
                if (pos_q.size() == 0)
                begin
                    ignored_takes++;
                    return 1'b0;
                end
                from_neg = 1'b0;
            end
            PREF_NEG:
            begin
                if (neg_q.size() == 0)
                begin
                    ignored_takes++;
                    return 1'b0;
                end
                from_neg = 1'b1;
            end
            PREF_OLDEST:
            begin
                if (pos_q.size() != 0 && neg_q.size() != 0)
                begin
                    age_gap = neg_q[0].serial - pos_q[0].serial;
                    from_neg = age_gap[31];
                end
                else if (neg_q.size() != 0)
                    from_neg = 1'b1;
                else if (pos_q.size() != 0)
                    from_neg = 1'b0;
                else
                begin
                    ignored_takes++;
                    return 1'b0;
                end
            end
            default:
            begin
                ignored_takes++;
                return 1'b0;
            end
        endcase
        if (from_neg)
            e = neg_q.pop_front();
        else
            e = pos_q.pop_front();
        out_id = e.id;
        return 1'b1;
    endfunction

    // random identifier with zero and the extremes mixed in
    function automatic logic signed [31:0] pick_id();
        case ($urandom_range(0, 15))
            0:       return 32'sd0;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh8000_0000;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // nonzero random identifier of one class
    function automatic logic signed [31:0] pick_class_id(input bit neg);
        logic [31:0] v;
        v = $urandom;
        v[31] = neg;
        if (v == 0)
            v = 32'd1;
        return v;
    endfunction

    function automatic logic [1:0] pick_pref();
        case ($urandom_range(0, 9))
            0:          return PREF_NONE;
            1, 2, 3, 4: return PREF_OLDEST;
            5, 6, 7:    return PREF_POS;
            default:    return PREF_NEG;
        endcase
    endfunction

    // offer one request item, entered and left at a falling edge
    task automatic send_req(input logic mode, input logic signed [31:0] id,
                            input logic [1:0] pref, input chk_kind_t chk = CHK_MODEL,
                            input logic signed [31:0] want = '0);
        int                 gap;
        bit                 hit;
        logic signed [31:0] model_id;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.mode       <= mode;
        in_if.entry_id   <= id;
        in_if.preference <= pref;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        hit = shelter_step(mode, id, pref, model_id);
        case (chk)
            CHK_MODEL:
                if (hit)
                    taken_q = {taken_q, model_id};
            CHK_ID:
                taken_q = {taken_q, want};
            default:
                ;
        endcase
        items_sent++;
        @(negedge clk);
    endtask

    // request side
    initial
    begin
        int cls;
        int n;
        int seg;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_ARRIVE;
        in_if.entry_id   = '0;
        in_if.preference = PREF_OLDEST;
        serial_ctr       = 32'd1;
        @(posedge rst_n);
        @(negedge clk);

        // directed rows
        foreach (dir_tab[i])
            send_req(dir_tab[i].mode, dir_tab[i].entry_id, dir_tab[i].pref,
                     dir_tab[i].chk, dir_tab[i].want);

        // wait for every taken id, then stall the result side and pile up takes
        in_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (taken_q.size() != 0);
        hold_rx  = 1'b1;
        tx_quiet = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            send_req(MODE_ARRIVE, pick_class_id(1'b0), PREF_OLDEST);
            send_req(MODE_ARRIVE, pick_class_id(1'b1), PREF_OLDEST);
        end
        repeat (16) send_req(MODE_TAKE, $urandom, PREF_OLDEST);

        // random segments
        while (items_sent < TOTAL_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            seg = $urandom_range(0, 9);
            if (seg < 2)
            begin
                // overfill one class, then drain it
                cls = $urandom_range(0, 1);
                n = $urandom_range(QUEUE_DEPTH_DEF, QUEUE_DEPTH_DEF + 4);
                repeat (n)
                    send_req(MODE_ARRIVE,
                             ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_class_id(cls[0]),
                             2'($urandom));
                repeat (n + 2)
                    send_req(MODE_TAKE, $urandom,
                             ($urandom_range(0, 3) == 0) ? PREF_OLDEST :
                             (cls != 0) ? PREF_NEG : PREF_POS);
            end
            else if (seg == 2)
            begin
                // pause until nothing is outstanding
                in_if.valid <= 1'b0;
                do
                    @(negedge clk);
                while (taken_q.size() != 0);
            end
            else
            begin
                repeat (30)
                begin
                    if ($urandom_range(0, 1) != 0)
                        send_req(MODE_TAKE, $urandom, pick_pref());
                    else
                        send_req(MODE_ARRIVE, pick_id(), 2'($urandom));
                end
            end
        end

        // drain and report
        in_if.valid <= 1'b0;
        while (taken_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d request items and %0d taken ids checked in order",
                 items_sent, ids_checked);
        $display("arrivals dropped on full class %0d, on zero id %0d; takes ignored %0d",
                 full_drops, zero_drops, ignored_takes);
        if (errors == 0)
            $display("tb_two_class_age_ordered_fifo OK");
        else
            $display("tb_two_class_age_ordered_fifo NOT OK");
        $finish;
    end

    // result side: random stalls, one long hold when asked
    initial
    begin
        int stall;
        int served;
        served = 0;
        out_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_rx)
            begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rx = 1'b0;
            end
            if (served % 40 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0)
            begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1) && !hold_rx);
            served++;
            @(negedge clk);
        end
    end

    // result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
            begin
                if (taken_q.size() == 0)
                begin
                    $error("taken_id: expected no item, got %0d", out_if.taken_id);
                    errors++;
                end
                else
                begin
                    want_id = taken_q.pop_front();
                    if (out_if.taken_id !== want_id)
                    begin
                        $error("taken_id: expected %0d, got %0d", want_id, out_if.taken_id);
                        errors++;
                    end
                    ids_checked++;
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("tb_two_class_age_ordered_fifo NOT OK");
                $finish;
            end
        end
    end

endmodule
